// ----- src/sha256_byte_stream_hasher_assert.svh -----
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rstn, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) cond |=> nxt) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define SHA_ASSERT_NEXT(label, clk, rstn, cond, nxt, msg)
`endif
`endif

// ----- src/sha_pkg.sv -----
// Package with SHA-256 constants, functions and shared types.
`default_nettype none
package sha_pkg;
    localparam int RoundCount = 64;

    typedef logic [31:0] word_t;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_COMP   = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_INIT   = 3'd4;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Start echo and busy status from the compression core to the controller.
    typedef struct packed {
        logic start;
        logic busy;
    } comp_ctl_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam word_t KTAB [0:63] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ----- src/sha_comp.sv -----
// SHA-256 compression core: block and schedule memories, one round per cycle.
`default_nettype none
module sha_comp
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Byte writes into the block buffer.
    input  wire logic        buf_we,
    input  wire logic [5:0]  buf_addr,
    input  wire logic [7:0]  buf_wdata,
    input  wire logic        comp_start,
    output comp_ctl_t        comp_ctl,
    // Hash word read port, and reset of the hash to its initial values.
    input  wire logic [2:0]  hash_raddr,
    output word_t            hash_rdata,
    input  wire logic        hash_init
);
    // Block buffer as 16 words, one byte lane written at a time.
    logic [7:0] blk_mem [0:15][0:3];
    word_t      sch_mem [0:15];
    word_t      hash_reg [0:7];
    word_t      var_reg [0:7];
    logic [6:0] rnd_reg;
    logic       run_reg;
    logic       fin_reg;
    word_t      blk_q_reg;
    word_t      s2_reg, s7_reg, s15_reg, s16_reg;
    word_t      w_cur;
    word_t      s0, s1, t1, t2;
    logic [3:0] rd_idx;
    logic [5:0] t6;

    assign t6 = rnd_reg[5:0];
    // Reads are registered in the cycle before their round; rnd counts from 0 and round t uses reads made at t-1.
    assign rd_idx = t6[3:0];

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            blk_mem[buf_addr[5:2]][buf_addr[1:0]] <= buf_wdata;
        end
    end

    // Prefetch registers hold the words needed for the next round.
    logic [5:0] nt;
    assign nt = t6 + 6'd1;
    always_ff @(posedge aclk) begin
        if (comp_start) begin
            blk_q_reg <= {blk_mem[0][0], blk_mem[0][1], blk_mem[0][2], blk_mem[0][3]};
        end else begin
            blk_q_reg <= {blk_mem[nt[3:0]][0], blk_mem[nt[3:0]][1],
                          blk_mem[nt[3:0]][2], blk_mem[nt[3:0]][3]};
        end
    end

    // Schedule window: shifted taps kept in registers, entries stored in memory.
    always_comb begin
        s0 = rotr(s15_reg, 7) ^ rotr(s15_reg, 18) ^ (s15_reg >> 3);
        s1 = rotr(s2_reg, 17) ^ rotr(s2_reg, 19) ^ (s2_reg >> 10);
        w_cur = (rnd_reg < 7'd16) ? blk_q_reg : (s1 + s7_reg + s0 + s16_reg);
        t1 = var_reg[7] + (rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25))
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6])) + KTAB[t6] + w_cur;
        t2 = (rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22))
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]));
    end

    logic [3:0] i2, i7, i15, i16;
    assign i2  = rd_idx + 4'd15;
    assign i7  = rd_idx + 4'd10;
    assign i15 = rd_idx + 4'd2;
    assign i16 = rd_idx + 4'd1;

    always_ff @(posedge aclk) begin
        if (run_reg) begin
            sch_mem[rd_idx] <= w_cur;
        end
        // Next round's taps; none of them is the entry written in this cycle.
        s2_reg  <= sch_mem[i2];
        s7_reg  <= sch_mem[i7];
        s15_reg <= sch_mem[i15];
        s16_reg <= sch_mem[i16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            rnd_reg <= '0;
        end else begin
            fin_reg <= !comp_start && run_reg && (rnd_reg == 7'(RoundCount - 1));
            if (comp_start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end else if (run_reg) begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'(RoundCount - 1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || hash_init) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_hash(3'(i));
        end else if (fin_reg) begin
            for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + var_reg[i];
        end
        if (comp_start) begin
            for (int i = 0; i < 8; i++) var_reg[i] <= hash_reg[i];
        end else if (run_reg) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    assign comp_ctl.start = comp_start;
    assign comp_ctl.busy  = run_reg | fin_reg;
    assign hash_rdata     = hash_reg[hash_raddr];
endmodule
`default_nettype wire

// ----- src/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher: control, padding and digest output.
//  Channel | Ports      | Payload
//  input   | s_axis_*   | tuser = opcode, tdata[7:0] = data_byte
//  result  | m_axis_*   | tdata[31:0] = digest_word, [34:32] = word_index; tlast = last_word
// An append that fills a block also starts a compression of 64 rounds.
// A finish writes the padding, runs one or two compressions, then makes 8 transfers.
// Reset is synchronous and active low. A stalled result holds the controller.
`default_nettype none
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word, word_index, zero fill
    output logic             m_axis_tlast    // last_word
);
    logic [2:0]  state_reg;
    logic [5:0]  pend_reg;
    logic [63:0] bits_reg;
    logic [63:0] total_reg;
    logic [6:0]  pad_reg;
    logic        extra_reg;
    logic        kick_reg;
    logic        kick_next;
    logic [2:0]  widx_reg;
    logic        ovld_reg;
    word_t       hash_rdata;
    comp_ctl_t   comp_ctl;
    logic        buf_we;
    logic [5:0]  buf_addr;
    logic [7:0]  buf_wdata;
    logic        acc;

    assign s_axis_tready = (state_reg == ST_IDLE) && !comp_ctl.busy && !kick_reg;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        buf_we = 1'b0;
        buf_addr = pend_reg;
        buf_wdata = s_axis_tdata;
        if (acc && s_axis_tuser == OP_APPEND) begin
            buf_we = 1'b1;
        end else if (acc) begin
            buf_we = 1'b1;
            buf_wdata = 8'h80;
        end else if (state_reg == ST_PAD && !pad_reg[6]) begin
            buf_we = 1'b1;
            buf_addr = pad_reg[5:0];
            if (!extra_reg && pad_reg >= 7'd56) begin
                buf_wdata = total_reg[8'(63 - 8 * (pad_reg - 7'd56)) -: 8];
            end else begin
                buf_wdata = 8'h00;
            end
        end
    end

    // A full block or the end of padding starts a compression in the next cycle.
    // When the marker byte lands in the last slot, padding has nothing left to write.
    always_comb begin
        kick_next = 1'b0;
        if (acc && s_axis_tuser == OP_APPEND && pend_reg == 6'd63) begin
            kick_next = 1'b1;
        end
        if (state_reg == ST_PAD && pad_reg >= 7'd63) begin
            kick_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            bits_reg  <= '0;
            kick_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
            widx_reg  <= '0;
            pad_reg   <= '0;
            extra_reg <= 1'b0;
            total_reg <= '0;
        end else begin
            kick_reg <= kick_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (acc && s_axis_tuser == OP_APPEND) begin
                        pend_reg <= pend_reg + 6'd1;
                        if (pend_reg == 6'd63) begin
                            bits_reg <= bits_reg + 64'd512;
                        end
                    end else if (acc) begin
                        total_reg <= bits_reg + {55'd0, pend_reg, 3'd0};
                        pad_reg   <= {1'b0, pend_reg} + 7'd1;
                        extra_reg <= (pend_reg >= 6'd56);
                        state_reg <= ST_PAD;
                    end
                end
                ST_PAD: begin
                    if (pad_reg >= 7'd63) begin
                        state_reg <= ST_COMP;
                    end
                    pad_reg <= pad_reg + 7'd1;
                end
                ST_COMP: begin
                    if (!kick_reg && !comp_ctl.busy) begin
                        if (extra_reg) begin
                            extra_reg <= 1'b0;
                            pad_reg   <= '0;
                            state_reg <= ST_PAD;
                        end else begin
                            widx_reg  <= '0;
                            ovld_reg  <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (m_axis_tready) begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7) begin
                            ovld_reg  <= 1'b0;
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    pend_reg  <= '0;
                    bits_reg  <= '0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    sha_comp u_comp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .buf_we     (buf_we),
        .buf_addr   (buf_addr),
        .buf_wdata  (buf_wdata),
        .comp_start (kick_reg),
        .comp_ctl   (comp_ctl),
        .hash_raddr (widx_reg),
        .hash_rdata (hash_rdata),
        .hash_init  (state_reg == ST_INIT)
    );

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {5'd0, widx_reg, hash_rdata};
    assign m_axis_tlast  = (widx_reg == 3'd7);

    `include "sha256_byte_stream_hasher_assert.svh"
    `SHA_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, !(s_axis_tready && m_axis_tvalid), "input ready during output")
    `SHA_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "output after last word")
    `SHA_ASSERT_IMPL(a_busy_blocks, aclk, aresetn, !(comp_ctl.busy && s_axis_tready), "ready while compressing")
endmodule
`default_nettype wire
